>>> hw/rtl/gep_pkg.sv
// Package with sizes, register indexes and types of the greedy edge partitioner.
package gep_pkg;

  localparam int MAX_PARTS = 8;
  localparam int MAX_NODES = 1024;

  localparam int PART_W = $clog2(MAX_PARTS);
  localparam int NODE_W = $clog2(MAX_NODES);

  // Field widths of the words on the ports.
  localparam int NODE_FIELD_W  = 10;
  localparam int PART_FIELD_W  = 3;
  localparam int PCOUNT_W      = 4;
  localparam int BOUND_W       = 16;
  localparam int REPLICA_W     = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Width that holds both the part count register and the number of parts.
  localparam int ACT_W = (PART_W + 1 > PCOUNT_W) ? PART_W + 1 : PCOUNT_W;

  localparam logic [REPLICA_W-1:0] REPLICA_MAX = {REPLICA_W{1'b1}};

  typedef logic [MAX_PARTS-1:0] row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART_COUNT = 2'd0,
    REG_SIZE_BOUND = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_ASSIGN = 1'b0,
    CMD_CLEAR  = 1'b1
  } command_e;

endpackage

>>> hw/rtl/greedy_edge_partitioner_top.sv
// Top level of the streaming greedy edge partitioner.
//
// Each input word carries one edge (two node numbers) or a clear command. The
// block keeps one membership row per node in a 1024 x 8 memory with two read
// ports and one write port, plus per-part edge counters and a running replica
// total. An edge is read from memory at the edge where it is accepted, then
// scored and placed from the working stage registers, and its result word lands
// in an output register, so a new edge is taken every cycle while the output
// is not stalled. Another exception comes from the single write port: when an
// edge sets a new bit in two different node rows, the second row is written in
// the following cycle, and the input is held while the first row is written.
// A write that lands at the same edge as the next read is forwarded, so
// back-to-back edges on the same nodes see up-to-date rows. After reset and
// after every clear command the memory is swept to zero, one row per cycle;
// the clear result word is delivered at once, while input words wait until
// the sweep is done. Configuration writes are always taken and should only
// be issued while the block is idle.
module greedy_edge_partitioner_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gep_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gep_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [gep_pkg::NODE_FIELD_W-1:0]    first_node_i,
  input  logic [gep_pkg::NODE_FIELD_W-1:0]    second_node_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [gep_pkg::PART_FIELD_W-1:0]    assigned_part_o,
  output logic [1:0]                          shared_endpoints_o,
  output logic [gep_pkg::REPLICA_W-1:0]       replica_total_o,
  output logic                                no_room_o
);

  localparam int NW = gep_pkg::NODE_W;
  localparam int PW = gep_pkg::PART_W;
  localparam int NP = gep_pkg::MAX_PARTS;

  // Configuration registers.
  logic [gep_pkg::PCOUNT_W-1:0] part_count_q;
  logic [gep_pkg::BOUND_W-1:0]  size_bound_q;

  // Membership memory.
  gep_pkg::row_t mem_q [gep_pkg::MAX_NODES];
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  gep_pkg::row_t mem_wdata;

  // Working stage, loaded at the accept edge together with the memory reads.
  logic          s1_valid_q, s1_valid_d;
  logic          s1_cmd_q;
  logic [NW-1:0] s1_u_q, s1_v_q;
  gep_pkg::row_t rd_u_q, rd_v_q;

  // Last memory write, for forwarding to a read taken at the same edge.
  logic          lw_valid_q, lw_valid_d;
  logic [NW-1:0] lw_addr_q;
  gep_pkg::row_t lw_data_q;

  // Deferred second row write.
  logic          pend_q, pend_d;
  logic [NW-1:0] pend_addr_q, pend_addr_d;
  gep_pkg::row_t pend_data_q, pend_data_d;

  // Clearing sweep.
  logic          clear_busy_q, clear_busy_d;
  logic [NW-1:0] clear_addr_q, clear_addr_d;

  // Per-part edge counts and replica total.
  logic [gep_pkg::BOUND_W-1:0]   count_q [NP];
  logic [gep_pkg::BOUND_W-1:0]   count_d [NP];
  logic [gep_pkg::REPLICA_W-1:0] replica_q, replica_d;

  // Output register.
  logic                             out_valid_q, out_valid_d;
  logic [gep_pkg::PART_FIELD_W-1:0] out_part_q, out_part_d;
  logic [1:0]                       out_shared_q, out_shared_d;
  logic [gep_pkg::REPLICA_W-1:0]    out_replica_q, out_replica_d;
  logic                             out_no_room_q, out_no_room_d;

  // Scoring and placement signals.
  logic                    in_accept;
  logic                    s1_adv;
  gep_pkg::row_t           row_u, row_v;
  logic [gep_pkg::ACT_W-1:0] active;
  logic [NP-1:0]           eligible;
  logic                    found;
  logic [PW-1:0]           best;
  logic [1:0]              best_score;
  logic [1:0]              score;
  gep_pkg::row_t           mask;
  logic                    assign_ok;
  logic                    new_u, new_v;
  logic                    two_writes;
  logic                    wr_now_en;
  logic [NW-1:0]           wr_now_addr;
  gep_pkg::row_t           wr_now_data;
  logic [1:0]              rep_inc;
  logic [gep_pkg::REPLICA_W:0] rep_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q <= gep_pkg::PCOUNT_W'(8);
      size_bound_q <= {gep_pkg::BOUND_W{1'b1}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gep_pkg::cfg_reg_e'(cfg_index_i))
        gep_pkg::REG_PART_COUNT: part_count_q <= cfg_data_i[gep_pkg::PCOUNT_W-1:0];
        gep_pkg::REG_SIZE_BOUND: size_bound_q <= cfg_data_i[gep_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // The stage can hand its result on when the output register is free or
  // being taken in this cycle.
  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);

  // Forward the write that landed at the edge where this word was read.
  assign row_u = (lw_valid_q && lw_addr_q == s1_u_q) ? lw_data_q : rd_u_q;
  assign row_v = (lw_valid_q && lw_addr_q == s1_v_q) ? lw_data_q : rd_v_q;

  assign active = (gep_pkg::ACT_W'(part_count_q) > gep_pkg::ACT_W'(NP))
                  ? gep_pkg::ACT_W'(NP) : gep_pkg::ACT_W'(part_count_q);

  always_comb begin
    for (int j = 0; j < NP; j++) begin
      eligible[j] = (gep_pkg::ACT_W'(j) < active) && (count_q[j] < size_bound_q);
    end
  end

  // Highest score wins; a strict compare keeps ties on the lowest part.
  always_comb begin
    found      = 1'b0;
    best       = '0;
    best_score = '0;
    score      = '0;
    for (int j = 0; j < NP; j++) begin
      score = {1'b0, row_u[j]} + {1'b0, row_v[j]};
      if (eligible[j] && (!found || score > best_score)) begin
        found      = 1'b1;
        best       = PW'(j);
        best_score = score;
      end
    end
  end

  assign mask      = gep_pkg::row_t'(1) << best;
  assign assign_ok = s1_adv && (s1_cmd_q == gep_pkg::CMD_ASSIGN) && found;
  assign new_u     = (row_u & mask) == '0;
  // A self loop touches one row only.
  assign new_v     = ((row_v & mask) == '0) && (s1_u_q != s1_v_q);
  assign two_writes = s1_valid_q && (s1_cmd_q == gep_pkg::CMD_ASSIGN) && found &&
                      new_u && new_v;

  always_comb begin
    wr_now_en   = 1'b0;
    wr_now_addr = s1_u_q;
    wr_now_data = row_u | mask;
    if (assign_ok) begin
      if (new_u) begin
        wr_now_en = 1'b1;
      end else if (new_v) begin
        wr_now_en   = 1'b1;
        wr_now_addr = s1_v_q;
        wr_now_data = row_v | mask;
      end
    end
  end

  assign rep_inc = {1'b0, new_u} + {1'b0, new_v};
  assign rep_sum = {1'b0, replica_q} + (gep_pkg::REPLICA_W + 1)'(rep_inc);

  // Hold input during the sweep, while a clear or an edge that needs a second row
  // write sits in the stage, and while the stage cannot move on.
  assign in_stall_o = clear_busy_q ||
                      (s1_valid_q && ((s1_cmd_q == gep_pkg::CMD_CLEAR) || two_writes ||
                                      !s1_adv));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Memory write port: sweep, then deferred row, then the current edge.
  always_comb begin
    if (clear_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr_q;
      mem_wdata = '0;
    end else if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_data_q;
    end else begin
      mem_we    = wr_now_en;
      mem_waddr = wr_now_addr;
      mem_wdata = wr_now_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_u_q <= mem_q[NW'(first_node_i)];
      rd_v_q <= mem_q[NW'(second_node_i)];
    end
  end

  always_comb begin
    s1_valid_d    = in_accept || (s1_valid_q && !s1_adv);
    pend_d        = assign_ok && new_u && new_v;
    pend_addr_d   = s1_v_q;
    pend_data_d   = row_v | mask;
    clear_busy_d  = clear_busy_q;
    clear_addr_d  = clear_addr_q;
    lw_valid_d    = lw_valid_q || mem_we;
    replica_d     = replica_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_part_d    = out_part_q;
    out_shared_d  = out_shared_q;
    out_replica_d = out_replica_q;
    out_no_room_d = out_no_room_q;

    if (clear_busy_q) begin
      clear_addr_d = clear_addr_q + NW'(1);
      lw_valid_d   = 1'b0;
      if (clear_addr_q == {NW{1'b1}}) begin
        clear_busy_d = 1'b0;
      end
    end

    if (s1_adv) begin
      out_valid_d = 1'b1;
      if (s1_cmd_q == gep_pkg::CMD_CLEAR) begin
        for (int j = 0; j < NP; j++) begin
          count_d[j] = '0;
        end
        replica_d     = '0;
        clear_busy_d  = 1'b1;
        clear_addr_d  = '0;
        lw_valid_d    = 1'b0;
        out_part_d    = '0;
        out_shared_d  = '0;
        out_replica_d = '0;
        out_no_room_d = 1'b0;
      end else if (!found) begin
        out_part_d    = '0;
        out_shared_d  = '0;
        out_replica_d = replica_q;
        out_no_room_d = 1'b1;
      end else begin
        count_d[best] = count_q[best] + gep_pkg::BOUND_W'(1);
        replica_d     = (rep_sum > (gep_pkg::REPLICA_W + 1)'(gep_pkg::REPLICA_MAX))
                        ? gep_pkg::REPLICA_MAX : rep_sum[gep_pkg::REPLICA_W-1:0];
        out_part_d    = gep_pkg::PART_FIELD_W'(best);
        out_shared_d  = best_score;
        out_replica_d = replica_d;
        out_no_room_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pend_q       <= 1'b0;
      lw_valid_q   <= 1'b0;
      clear_busy_q <= 1'b1;
      clear_addr_q <= '0;
      replica_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int j = 0; j < NP; j++) begin
        count_q[j] <= '0;
      end
    end else begin
      s1_valid_q   <= s1_valid_d;
      pend_q       <= pend_d;
      lw_valid_q   <= lw_valid_d;
      clear_busy_q <= clear_busy_d;
      clear_addr_q <= clear_addr_d;
      replica_q    <= replica_d;
      out_valid_q  <= out_valid_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q <= command_i;
      s1_u_q   <= NW'(first_node_i);
      s1_v_q   <= NW'(second_node_i);
    end
    if (mem_we) begin
      lw_addr_q <= mem_waddr;
      lw_data_q <= mem_wdata;
    end
    pend_addr_q   <= pend_addr_d;
    pend_data_q   <= pend_data_d;
    out_part_q    <= out_part_d;
    out_shared_q  <= out_shared_d;
    out_replica_q <= out_replica_d;
    out_no_room_q <= out_no_room_d;
  end

  assign out_valid_o        = out_valid_q;
  assign assigned_part_o    = out_part_q;
  assign shared_endpoints_o = out_shared_q;
  assign replica_total_o    = out_replica_q;
  assign no_room_o          = out_no_room_q;

  // A deferred row write is never followed by another one.
  a_pend_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pend_d)
    else $error("deferred row writes chained");

  // The sweep runs with the working stage and the write queue empty.
  a_sweep_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy_q |-> (!s1_valid_q && !pend_q))
    else $error("sweep overlaps edge processing");

  // The replica total only grows between clears.
  a_replica_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_cmd_q == gep_pkg::CMD_ASSIGN) |=> replica_q >= $past(replica_q))
    else $error("replica total decreased");

  // A word without room carries no part and no shared count.
  a_no_room_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_no_room_q) |-> (out_part_q == '0 && out_shared_q == '0))
    else $error("no-room word carries a part");

endmodule

>>> sim/greedy_edge_partitioner_top_tb.sv
// Self-checking testbench for the greedy edge partitioner: directed table, random edges, predictor.
`timescale 1ns / 100ps

module greedy_edge_partitioner_top_tb;

  // A run is declared hung after this many cycles in which no word moves on any
  // channel. The longest legal quiet stretch is the memory sweep after reset or a
  // clear, plus receiver stalls and sender gaps, and the limit leaves ample margin.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 5;
  localparam int WORDS_PER_PHASE = 220;
  localparam int REPORT_LIMIT = 10;

  // One result word, field for field as it appears on the output ports.
  typedef struct packed {
    logic [gep_pkg::PART_FIELD_W-1:0] part;
    logic [1:0]                       shared;
    logic [gep_pkg::REPLICA_W-1:0]    total;
    logic                             no_room;
  } result_t;

  // A row of the directed table either writes a register or sends one word.
  typedef enum bit {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e                         kind;
    gep_pkg::cfg_reg_e                 reg_idx;
    logic [gep_pkg::CFG_DATA_W-1:0]    reg_value;
    gep_pkg::command_e                 cmd;
    logic [gep_pkg::NODE_FIELD_W-1:0]  node_a;
    logic [gep_pkg::NODE_FIELD_W-1:0]  node_b;
    bit                                typed;
    result_t                           want;
  } plan_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [gep_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [gep_pkg::CFG_DATA_W-1:0]    cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              command_i;
  logic [gep_pkg::NODE_FIELD_W-1:0]  first_node_i;
  logic [gep_pkg::NODE_FIELD_W-1:0]  second_node_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [gep_pkg::PART_FIELD_W-1:0]  assigned_part_o;
  logic [1:0]                        shared_endpoints_o;
  logic [gep_pkg::REPLICA_W-1:0]     replica_total_o;
  logic                              no_room_o;

  greedy_edge_partitioner_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .first_node_i       (first_node_i),
    .second_node_i      (second_node_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .assigned_part_o    (assigned_part_o),
    .shared_endpoints_o (shared_endpoints_o),
    .replica_total_o    (replica_total_o),
    .no_room_o          (no_room_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the partitioner: membership bitmap, per-part edge fill,
  // replica total and the two registers.
  bit [gep_pkg::MAX_PARTS-1:0]     member_rows [gep_pkg::MAX_NODES];
  int unsigned                     part_fill [gep_pkg::MAX_PARTS];
  logic [gep_pkg::REPLICA_W-1:0]   replica_sum;
  logic [gep_pkg::PCOUNT_W-1:0]    part_limit;
  logic [gep_pkg::BOUND_W-1:0]     edge_bound;

  // Result words predicted for accepted input words, oldest first.
  result_t   pending_results [$];
  plan_row_t directed_plan [$];

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  // While hush is set, neither side inserts gaps or stalls.
  bit  hush;

  // Works out the result word for one command and advances the shadow state.
  function automatic result_t place_edge(gep_pkg::command_e cmd,
                                         logic [gep_pkg::NODE_FIELD_W-1:0] node_a,
                                         logic [gep_pkg::NODE_FIELD_W-1:0] node_b);
    result_t     res;
    int unsigned live_parts;
    int unsigned score;
    int unsigned best_score;
    int          best_part;
    bit          found;
    res = '0;
    found = 1'b0;
    best_part = 0;
    best_score = 0;
    if (cmd == gep_pkg::CMD_CLEAR) begin
      foreach (member_rows[n]) member_rows[n] = '0;
      foreach (part_fill[p]) part_fill[p] = 0;
      replica_sum = '0;
      return res;
    end
    // Part counts above the number of parts saturate.
    live_parts = (part_limit > gep_pkg::MAX_PARTS) ? gep_pkg::MAX_PARTS : part_limit;
    for (int p = 0; p < live_parts; p++) begin
      if (part_fill[p] < edge_bound) begin
        score = int'(member_rows[node_a][p]) + int'(member_rows[node_b][p]);
        // Strictly greater keeps the lowest index on a tie.
        if (!found || score > best_score) begin
          found = 1'b1;
          best_part = p;
          best_score = score;
        end
      end
    end
    if (!found) begin
      res.no_room = 1'b1;
      res.total = replica_sum;
      return res;
    end
    // A self-loop sets its node once, so the second test sees the bit set.
    if (!member_rows[node_a][best_part]) begin
      member_rows[node_a][best_part] = 1'b1;
      if (replica_sum != gep_pkg::REPLICA_MAX) replica_sum++;
    end
    if (!member_rows[node_b][best_part]) begin
      member_rows[node_b][best_part] = 1'b1;
      if (replica_sum != gep_pkg::REPLICA_MAX) replica_sum++;
    end
    part_fill[best_part]++;
    res.part = gep_pkg::PART_FIELD_W'(best_part);
    res.shared = 2'(best_score);
    res.total = replica_sum;
    return res;
  endfunction

  task automatic add_reg_row(gep_pkg::cfg_reg_e idx, logic [gep_pkg::CFG_DATA_W-1:0] value);
    plan_row_t row;
    row = '{kind: ROW_REG, reg_idx: idx, reg_value: value, cmd: gep_pkg::CMD_ASSIGN,
            node_a: '0, node_b: '0, typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endtask

  task automatic add_word_row(gep_pkg::command_e cmd,
                              logic [gep_pkg::NODE_FIELD_W-1:0] node_a,
                              logic [gep_pkg::NODE_FIELD_W-1:0] node_b);
    plan_row_t row;
    row = '{kind: ROW_WORD, reg_idx: gep_pkg::REG_PART_COUNT, reg_value: '0, cmd: cmd,
            node_a: node_a, node_b: node_b, typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endtask

  // A word whose result is known by inspection and typed in directly.
  task automatic add_known_row(gep_pkg::command_e cmd,
                               logic [gep_pkg::NODE_FIELD_W-1:0] node_a,
                               logic [gep_pkg::NODE_FIELD_W-1:0] node_b, int part, int shared,
                               int total, bit no_room);
    plan_row_t row;
    row = '{kind: ROW_WORD, reg_idx: gep_pkg::REG_PART_COUNT, reg_value: '0, cmd: cmd,
            node_a: node_a, node_b: node_b, typed: 1'b1, want: '0};
    row.want.part = gep_pkg::PART_FIELD_W'(part);
    row.want.shared = 2'(shared);
    row.want.total = gep_pkg::REPLICA_W'(total);
    row.want.no_room = no_room;
    directed_plan.push_back(row);
  endtask

  // Presents one word on the input channel and returns right after the rising
  // edge that accepts it. Valid stays high, so the next call can follow
  // back to back; any other caller drops valid at the next falling edge.
  task automatic send_word(gep_pkg::command_e cmd, logic [gep_pkg::NODE_FIELD_W-1:0] node_a,
                           logic [gep_pkg::NODE_FIELD_W-1:0] node_b, bit typed,
                           result_t want);
    result_t predicted;
    @(negedge clk_i);
    if (!hush && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    command_i = cmd;
    first_node_i = node_a;
    second_node_i = node_b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = place_edge(cmd, node_a, node_b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Registers change only once the block has drained: all expected words have
  // arrived, and a short pause covers a second-row write still in flight.
  task automatic write_reg(gep_pkg::cfg_reg_e idx, logic [gep_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == gep_pkg::REG_PART_COUNT) part_limit = value[gep_pkg::PCOUNT_W-1:0];
    else edge_bound = value[gep_pkg::BOUND_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // The receiver stalls in bursts of random length, changing at the falling
  // edge only.
  always @(negedge clk_i) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!hush && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    out_stall_i = (stall_left != 0);
  end

  // Every accepted output word is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_output
    result_t observed;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed.part = assigned_part_o;
      observed.shared = shared_endpoints_o;
      observed.total = replica_total_o;
      observed.no_room = no_room_o;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected word part %0d shared %0d total %0d no_room %0b",
                   $realtime, observed.part, observed.shared, observed.total,
                   observed.no_room);
      end else begin
        want = pending_results.pop_front();
        if (observed.part !== want.part || observed.shared !== want.shared ||
            observed.total !== want.total || observed.no_room !== want.no_room) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"%0t: expected part %0d shared %0d total %0d no_room %0b, ",
                      "got %0d %0d %0d %0b"},
                     $realtime, want.part, want.shared, want.total, want.no_room,
                     observed.part, observed.shared, observed.total, observed.no_room);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [gep_pkg::NODE_FIELD_W-1:0] hot_base;
    logic [gep_pkg::NODE_FIELD_W-1:0] node_a;
    logic [gep_pkg::NODE_FIELD_W-1:0] node_b;
    gep_pkg::command_e                cmd;
    int unsigned                      shape;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gep_pkg::REG_PART_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = gep_pkg::CMD_ASSIGN;
    first_node_i = '0;
    second_node_i = '0;
    hush = 1'b0;
    hot_base = '0;
    node_b = '0;
    replica_sum = '0;
    part_limit = gep_pkg::PCOUNT_W'(8);
    edge_bound = '1;

    // Directed table. The first rows run on the reset settings of eight parts
    // and no practical bound, so the results are plain to see: a self-loop on a
    // fresh node adds one replica, a fresh pair ties everywhere and lands in
    // part zero, and an edge whose nodes part zero already holds scores two.
    add_known_row(gep_pkg::CMD_ASSIGN, 10'd0, 10'd0, 0, 0, 1, 1'b0);
    add_known_row(gep_pkg::CMD_ASSIGN, 10'd1023, 10'd1023, 0, 0, 2, 1'b0);
    add_known_row(gep_pkg::CMD_ASSIGN, 10'd0, 10'd1023, 0, 2, 2, 1'b0);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd0, 10'd5);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'h2AA, 10'h155);
    // A clear returns an all-zero word whatever the node fields hold.
    add_known_row(gep_pkg::CMD_CLEAR, 10'd1023, 10'd1023, 0, 0, 0, 1'b0);
    add_known_row(gep_pkg::CMD_ASSIGN, 10'd1023, 10'd0, 0, 0, 2, 1'b0);
    // A bound of one edge per part pushes each new edge to the next free part.
    add_reg_row(gep_pkg::REG_SIZE_BOUND, 16'd1);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd1023, 10'd0);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd1023, 10'd1023);
    // With no part active every edge is refused.
    add_reg_row(gep_pkg::REG_PART_COUNT, 16'd0);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd3, 10'd4);
    // A part count above eight saturates to eight.
    add_reg_row(gep_pkg::REG_PART_COUNT, 16'd15);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd1023, 10'd0);
    // A bound of zero leaves no room anywhere.
    add_reg_row(gep_pkg::REG_SIZE_BOUND, 16'd0);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd7, 10'd8);
    add_reg_row(gep_pkg::REG_SIZE_BOUND, 16'hFFFF);
    add_reg_row(gep_pkg::REG_PART_COUNT, 16'd1);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd7, 10'd8);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd9, 10'd9);
    add_reg_row(gep_pkg::REG_PART_COUNT, 16'd8);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd7, 10'd9);
    add_word_row(gep_pkg::CMD_ASSIGN, 10'd512, 10'd1);
    add_known_row(gep_pkg::CMD_CLEAR, 10'd0, 10'd0, 0, 0, 0, 1'b0);

    // Reset is applied first and released at a falling edge; the block then sweeps its
    // memory, which the first input word simply waits out.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_value);
      else
        send_word(directed_plan[i].cmd, directed_plan[i].node_a, directed_plan[i].node_b,
                  directed_plan[i].typed, directed_plan[i].want);
    end

    // Random phases, each under its own settings. The last phase runs with no
    // gaps or stalls at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      hush = (phase == RANDOM_PHASES - 1);
      case (phase)
        0: begin
          write_reg(gep_pkg::REG_PART_COUNT, 16'd8);
          write_reg(gep_pkg::REG_SIZE_BOUND, 16'hFFFF);
        end
        1: begin
          write_reg(gep_pkg::REG_PART_COUNT, 16'($urandom_range(2, 4)));
          write_reg(gep_pkg::REG_SIZE_BOUND, 16'($urandom_range(16, 64)));
        end
        2: begin
          write_reg(gep_pkg::REG_PART_COUNT, 16'($urandom_range(9, 15)));
          write_reg(gep_pkg::REG_SIZE_BOUND, 16'($urandom_range(32, 128)));
        end
        3: begin
          // Tight bounds: parts fill up quickly and no_room is common until the
          // next clear.
          write_reg(gep_pkg::REG_PART_COUNT, 16'($urandom_range(1, 8)));
          write_reg(gep_pkg::REG_SIZE_BOUND, 16'($urandom_range(1, 8)));
        end
        default: begin
          write_reg(gep_pkg::REG_PART_COUNT, 16'($urandom_range(5, 8)));
          write_reg(gep_pkg::REG_SIZE_BOUND, 16'($urandom_range(40, 200)));
        end
      endcase

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // Edges mostly stay inside a small window of nodes, so endpoints repeat
        // and parts build up shared nodes; the window moves now and then.
        if (k % 40 == 0) hot_base = gep_pkg::NODE_FIELD_W'($urandom);
        // Calm stretches without any idling, except in the final phase where
        // idling is off throughout.
        if (k % 50 == 0 && phase != RANDOM_PHASES - 1) hush = ($urandom_range(0, 3) == 0);
        cmd = ($urandom_range(0, 47) == 0) ? gep_pkg::CMD_CLEAR : gep_pkg::CMD_ASSIGN;
        shape = $urandom_range(0, 9);
        if (shape <= 5) begin
          node_a = hot_base + gep_pkg::NODE_FIELD_W'($urandom_range(0, 15));
          node_b = hot_base + gep_pkg::NODE_FIELD_W'($urandom_range(0, 15));
        end else if (shape == 6) begin
          // Self-loop.
          node_a = hot_base + gep_pkg::NODE_FIELD_W'($urandom_range(0, 15));
          node_b = node_a;
        end else if (shape == 7) begin
          // Chain from the previous edge's second node.
          node_a = node_b;
          node_b = hot_base + gep_pkg::NODE_FIELD_W'($urandom_range(0, 15));
        end else begin
          node_a = gep_pkg::NODE_FIELD_W'($urandom);
          node_b = gep_pkg::NODE_FIELD_W'($urandom);
        end
        send_word(cmd, node_a, node_b, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gep_pkg.sv
hw/rtl/greedy_edge_partitioner_top.sv
sim/greedy_edge_partitioner_top_tb.sv
